// ----- rtl/llfb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llfb_pkg
// Shared types, codes and constants of the fully connected layer engine.
// ----------------------------------------------------------------------------
package llfb_pkg;

   localparam int DATA_W        = 16;
   localparam int FRAC_BITS     = 8;
   localparam int IDX_W         = 6;
   localparam int BATCH_REG_W   = 5;
   localparam int SIZE_REG_W    = 7;
   localparam int CSR_DATA_W    = 7;
   localparam int CSR_IDX_W     = 2;
   localparam int DEF_MAX_BATCH = 16;
   localparam int DEF_MAX_INNER = 64;
   localparam int DEF_MAX_OUT   = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_BATCH_ROWS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_SIZE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_COLUMNS = 2'd2;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [IDX_W-1:0]         idx_type;

   typedef enum logic [2:0] {
      CMD_WR_X  = 3'd0,
      CMD_WR_W  = 3'd1,
      CMD_WR_B  = 3'd2,
      CMD_WR_G  = 3'd3,
      CMD_RD_Y  = 3'd4,
      CMD_RD_DX = 3'd5,
      CMD_RD_DW = 3'd6,
      CMD_RD_DB = 3'd7
   } cmd_type;

   typedef struct packed {
      logic latch;
      logic exec;
      logic issue;
      logic finish;
   } ctl_cmd_type;

   typedef struct packed {
      logic is_read;
      logic range_err;
      logic last_issue;
      logic pipe_busy;
      logic out_free;
   } dp_status_type;

endpackage

// ----- rtl/llfb_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llfb_req_if
// Request channel: command, indices and write value.
// ----------------------------------------------------------------------------
interface llfb_req_if
   import llfb_pkg::*;
();
   logic     valid;
   logic     ready;
   cmd_type  cmd;
   idx_type  first_index;
   idx_type  second_index;
   data_type value;

   modport source (output valid, cmd, first_index, second_index, value, input ready);
   modport sink   (input valid, cmd, first_index, second_index, value, output ready);
endinterface

// ----- rtl/llfb_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llfb_rsp_if
// Response channel: result element, error status and saturation flag.
// ----------------------------------------------------------------------------
interface llfb_rsp_if
   import llfb_pkg::*;
();
   logic     valid;
   logic     ready;
   data_type result_value;
   logic     status;
   logic     saturated;

   modport source (output valid, result_value, status, saturated, input ready);
   modport sink   (input valid, result_value, status, saturated, output ready);
endinterface

// ----- rtl/llfb_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llfb_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module llfb_ram #(
   parameter  int WIDTH = 16,
   parameter  int DEPTH = 64,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/llfb_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llfb_ctrl
// Request sequencer: accept, execute, dot-product walk, drain, respond.
// ----------------------------------------------------------------------------
module llfb_ctrl
   import llfb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output ctl_cmd_type   ctl
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_EXEC   = 5'b00010,
      ST_RUN    = 5'b00100,
      ST_DRAIN  = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.latch = 1'b1;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            ctl.exec = 1'b1;
            if (status.is_read && !status.range_err) begin
               state_in = ST_RUN;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_RUN: begin
            ctl.issue = 1'b1;
            if (status.last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               ctl.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/llfb_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llfb_datapath
// Size registers, element stores, multiply-accumulate, rounding and
// saturation, and the response register.
// ----------------------------------------------------------------------------
module llfb_datapath
   import llfb_pkg::*;
#(
   parameter int MAX_BATCH = DEF_MAX_BATCH,
   parameter int MAX_INNER = DEF_MAX_INNER,
   parameter int MAX_OUT   = DEF_MAX_OUT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  cmd_type               req_cmd,
   input  idx_type               req_first_index,
   input  idx_type               req_second_index,
   input  data_type              req_value,
   input  logic                  rsp_ready,
   input  ctl_cmd_type           ctl,
   output dp_status_type         status,
   output logic                  rsp_valid,
   output data_type              rsp_result_value,
   output logic                  rsp_status,
   output logic                  rsp_saturated
);

   localparam int XDEPTH    = MAX_BATCH * MAX_INNER;
   localparam int WDEPTH    = MAX_OUT * MAX_INNER;
   localparam int BDEPTH    = MAX_OUT;
   localparam int GDEPTH    = MAX_BATCH * MAX_OUT;
   localparam int XAW       = (XDEPTH > 1) ? $clog2(XDEPTH) : 1;
   localparam int WAW       = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
   localparam int BAW       = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
   localparam int GAW       = (GDEPTH > 1) ? $clog2(GDEPTH) : 1;
   localparam int BATCH_LIM = (2 ** BATCH_REG_W) - 1;
   localparam int SIZE_LIM  = (2 ** SIZE_REG_W) - 1;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int ACC_W     = PROD_W + SIZE_REG_W + 2;

   localparam logic [BATCH_REG_W-1:0] BATCH_TOP =
      BATCH_REG_W'((MAX_BATCH > BATCH_LIM) ? BATCH_LIM : MAX_BATCH);
   localparam logic [SIZE_REG_W-1:0]  INNER_TOP =
      SIZE_REG_W'((MAX_INNER > SIZE_LIM) ? SIZE_LIM : MAX_INNER);
   localparam logic [SIZE_REG_W-1:0]  OUT_TOP   =
      SIZE_REG_W'((MAX_OUT > SIZE_LIM) ? SIZE_LIM : MAX_OUT);
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(2 ** (FRAC_BITS - 1));
   localparam data_type DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam data_type DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   // size registers
   logic [BATCH_REG_W-1:0] batch_rows_ff, batch_rows_in;
   logic [SIZE_REG_W-1:0]  inner_size_ff, inner_size_in;
   logic [SIZE_REG_W-1:0]  out_columns_ff, out_columns_in;
   logic [BATCH_REG_W-1:0] batch_wr;

   assign batch_wr = csr_wdata[BATCH_REG_W-1:0];

   always_comb begin
      batch_rows_in  = batch_rows_ff;
      inner_size_in  = inner_size_ff;
      out_columns_in = out_columns_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_BATCH_ROWS: begin
               batch_rows_in = (batch_wr == '0) ? BATCH_REG_W'(1) :
                               (batch_wr > BATCH_TOP) ? BATCH_TOP : batch_wr;
            end
            CSR_INNER_SIZE: begin
               inner_size_in = (csr_wdata == '0) ? SIZE_REG_W'(1) :
                               (csr_wdata > INNER_TOP) ? INNER_TOP : csr_wdata;
            end
            CSR_OUT_COLUMNS: begin
               out_columns_in = (csr_wdata == '0) ? SIZE_REG_W'(1) :
                                (csr_wdata > OUT_TOP) ? OUT_TOP : csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         batch_rows_ff  <= BATCH_TOP;
         inner_size_ff  <= INNER_TOP;
         out_columns_ff <= OUT_TOP;
      end else begin
         batch_rows_ff  <= batch_rows_in;
         inner_size_ff  <= inner_size_in;
         out_columns_ff <= out_columns_in;
      end
   end

   // latched request
   cmd_type  cmd_ff;
   idx_type  a_ff, b_ff;
   data_type value_ff;

   always_ff @(posedge clock) begin
      if (ctl.latch) begin
         cmd_ff   <= req_cmd;
         a_ff     <= req_first_index;
         b_ff     <= req_second_index;
         value_ff <= req_value;
      end
   end

   // range check and loop length
   logic [SIZE_REG_W-1:0] a_ext, b_ext, batch_ext, n_lim;
   logic                  a_in_batch, a_in_out, b_in_inner, b_in_out;
   logic                  range_err, is_read;

   assign a_ext      = SIZE_REG_W'(a_ff);
   assign b_ext      = SIZE_REG_W'(b_ff);
   assign batch_ext  = SIZE_REG_W'(batch_rows_ff);
   assign a_in_batch = a_ext < batch_ext;
   assign a_in_out   = a_ext < out_columns_ff;
   assign b_in_inner = b_ext < inner_size_ff;
   assign b_in_out   = b_ext < out_columns_ff;

   always_comb begin
      range_err = 1'b0;
      is_read   = 1'b0;
      n_lim     = inner_size_ff;
      unique case (cmd_ff) inside
         CMD_WR_X: begin
            range_err = !(a_in_batch && b_in_inner);
         end
         CMD_WR_W: begin
            range_err = !(a_in_out && b_in_inner);
         end
         CMD_WR_B: begin
            range_err = !a_in_out;
         end
         CMD_WR_G: begin
            range_err = !(a_in_batch && b_in_out);
         end
         CMD_RD_Y: begin
            range_err = !(a_in_batch && b_in_out);
            is_read   = 1'b1;
            n_lim     = inner_size_ff;
         end
         CMD_RD_DX: begin
            range_err = !(a_in_batch && b_in_inner);
            is_read   = 1'b1;
            n_lim     = out_columns_ff;
         end
         CMD_RD_DW: begin
            range_err = !(a_in_out && b_in_inner);
            is_read   = 1'b1;
            n_lim     = batch_ext;
         end
         CMD_RD_DB: begin
            range_err = !a_in_out;
            is_read   = 1'b1;
            n_lim     = batch_ext;
         end
         default: begin
         end
      endcase
   end

   // term counter
   logic [SIZE_REG_W-1:0] k_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= '0;
      end else if (ctl.exec) begin
         k_ff <= '0;
      end else if (ctl.issue) begin
         k_ff <= k_ff + SIZE_REG_W'(1);
      end
   end

   // stores
   logic                  wr_ok;
   logic [SIZE_REG_W-1:0] x_row, x_col, w_row, w_col, g_row, g_col;
   logic [DATA_W-1:0]     x_q, w_q, b_q, g_q;

   assign wr_ok = ctl.exec && !range_err;

   assign x_row = (cmd_ff == CMD_RD_DW) ? k_ff : a_ext;
   assign x_col = (cmd_ff == CMD_RD_Y) ? k_ff : b_ext;
   assign w_row = (cmd_ff == CMD_RD_DX) ? k_ff : b_ext;
   assign w_col = (cmd_ff == CMD_RD_DX) ? b_ext : k_ff;
   assign g_row = (cmd_ff == CMD_RD_DX) ? a_ext : k_ff;
   assign g_col = (cmd_ff == CMD_RD_DX) ? k_ff : a_ext;

   llfb_ram #(.WIDTH(DATA_W), .DEPTH(XDEPTH)) u_x_ram (
      .clock (clock),
      .we    (wr_ok && (cmd_ff == CMD_WR_X)),
      .waddr (XAW'(a_ff * MAX_INNER + b_ff)),
      .wdata (value_ff),
      .raddr (XAW'(x_row * MAX_INNER + x_col)),
      .rdata (x_q)
   );

   llfb_ram #(.WIDTH(DATA_W), .DEPTH(WDEPTH)) u_w_ram (
      .clock (clock),
      .we    (wr_ok && (cmd_ff == CMD_WR_W)),
      .waddr (WAW'(a_ff * MAX_INNER + b_ff)),
      .wdata (value_ff),
      .raddr (WAW'(w_row * MAX_INNER + w_col)),
      .rdata (w_q)
   );

   llfb_ram #(.WIDTH(DATA_W), .DEPTH(BDEPTH)) u_b_ram (
      .clock (clock),
      .we    (wr_ok && (cmd_ff == CMD_WR_B)),
      .waddr (BAW'(a_ff)),
      .wdata (value_ff),
      .raddr (BAW'(b_ff)),
      .rdata (b_q)
   );

   llfb_ram #(.WIDTH(DATA_W), .DEPTH(GDEPTH)) u_g_ram (
      .clock (clock),
      .we    (wr_ok && (cmd_ff == CMD_WR_G)),
      .waddr (GAW'(a_ff * MAX_OUT + b_ff)),
      .wdata (value_ff),
      .raddr (GAW'(g_row * MAX_OUT + g_col)),
      .rdata (g_q)
   );

   // multiply-accumulate
   data_type                  opa, opb, x_s, w_s, g_s, b_s;
   logic signed [PROD_W-1:0]  prod_in, prod_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic                      rd_valid_ff, prod_valid_ff, bias_load_ff;

   assign x_s = $signed(x_q);
   assign w_s = $signed(w_q);
   assign g_s = $signed(g_q);
   assign b_s = $signed(b_q);
   assign opa = (cmd_ff == CMD_RD_Y) ? x_s : g_s;
   assign opb = (cmd_ff == CMD_RD_DW) ? x_s : w_s;

   always_comb begin
      if (cmd_ff == CMD_RD_DB) begin
         prod_in = PROD_W'(g_s) <<< FRAC_BITS;
      end else begin
         prod_in = opa * opb;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (ctl.exec) begin
         acc_ff <= '0;
      end else if (bias_load_ff) begin
         acc_ff <= ACC_W'(b_s) <<< FRAC_BITS;
      end else if (prod_valid_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
         bias_load_ff  <= 1'b0;
      end else begin
         rd_valid_ff   <= ctl.issue;
         prod_valid_ff <= rd_valid_ff;
         bias_load_ff  <= ctl.exec && (cmd_ff == CMD_RD_Y);
      end
   end

   // round half up, saturate
   logic signed [ACC_W-1:0] rnd_t, rnd_q;
   logic                    sat_hi, sat_lo;
   data_type                rnd_val;

   assign rnd_t   = acc_ff + ROUND_HALF;
   assign rnd_q   = rnd_t >>> FRAC_BITS;
   assign sat_hi  = !rnd_q[ACC_W-1] && (|rnd_q[ACC_W-2:DATA_W-1]);
   assign sat_lo  = rnd_q[ACC_W-1] && !(&rnd_q[ACC_W-2:DATA_W-1]);
   assign rnd_val = sat_hi ? DATA_MAX : sat_lo ? DATA_MIN : data_type'(rnd_q[DATA_W-1:0]);

   // response register
   logic     rsp_valid_ff;
   data_type result_ff;
   logic     status_ff, sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.finish) begin
         if (range_err) begin
            result_ff <= '0;
            status_ff <= 1'b1;
            sat_ff    <= 1'b0;
         end else if (!is_read) begin
            result_ff <= '0;
            status_ff <= 1'b0;
            sat_ff    <= 1'b0;
         end else begin
            result_ff <= rnd_val;
            status_ff <= 1'b0;
            sat_ff    <= sat_hi || sat_lo;
         end
      end
   end

   assign status.is_read    = is_read;
   assign status.range_err  = range_err;
   assign status.last_issue = (k_ff == (n_lim - SIZE_REG_W'(1)));
   assign status.pipe_busy  = rd_valid_ff || prod_valid_ff || bias_load_ff;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = result_ff;
   assign rsp_status       = status_ff;
   assign rsp_saturated    = sat_ff;

endmodule

// ----- rtl/linear_layer_forward_backward.sv -----
`timescale 1ns / 1ps
// Sequence: a write is accepted, executed and answered; a read also walks n terms (n is
// inner_size for y, out_columns for dx, batch_rows for dW and db) and drains the pipe
// first; one request at a time, so none is taken until the last response is registered.
// The single multiply-accumulate unit is fed by one read port per store.
// Reset: synchronous, active high; sizes return to their maximum, stores hold
// nothing defined until written.
// ----------------------------------------------------------------------------
// linear_layer_forward_backward
// Fully connected layer engine: element writes and forward/backward reads.
// ----------------------------------------------------------------------------
module linear_layer_forward_backward
   import llfb_pkg::*;
#(
   parameter int MAX_BATCH = DEF_MAX_BATCH,
   parameter int MAX_INNER = DEF_MAX_INNER,
   parameter int MAX_OUT   = DEF_MAX_OUT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   llfb_req_if.sink              req_chan,
   llfb_rsp_if.source            rsp_chan
);

   ctl_cmd_type   ctl;
   dp_status_type status;

   llfb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .ctl       (ctl)
   );

   llfb_datapath #(
      .MAX_BATCH (MAX_BATCH),
      .MAX_INNER (MAX_INNER),
      .MAX_OUT   (MAX_OUT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_cmd          (req_chan.cmd),
      .req_first_index  (req_chan.first_index),
      .req_second_index (req_chan.second_index),
      .req_value        (req_chan.value),
      .rsp_ready        (rsp_chan.ready),
      .ctl              (ctl),
      .status           (status),
      .rsp_valid        (rsp_chan.valid),
      .rsp_result_value (rsp_chan.result_value),
      .rsp_status       (rsp_chan.status),
      .rsp_saturated    (rsp_chan.saturated)
   );

`ifndef SYNTHESIS
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("request taken while another is in flight");

   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status |->
         (rsp_chan.result_value == '0) && !rsp_chan.saturated)
      else $error("error response carries data");

   a_sat_extreme: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.saturated |->
         (rsp_chan.result_value == 16'sh7fff) || (rsp_chan.result_value == 16'sh8000))
      else $error("saturated response not at a range limit");

   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      ctl.finish |-> status.out_free)
      else $error("response written over an unread response");
`endif

endmodule
